// ===== src/npo_pkg.sv =====
// ----------------------------------------------------------------------------
// npo_pkg
// Shared beat types, register codes and fixed-point helpers of the
// nonlinear potential operator.
// ----------------------------------------------------------------------------
`default_nettype none

package npo_pkg;

    // Pipeline depth: six front stages (trap and nonlinear paths side by side),
    // then five scale and output stages.
    localparam int NUM_STAGES   = 11;
    localparam int FRONT_STAGES = 6;
    localparam int BACK_STAGES  = NUM_STAGES - FRONT_STAGES;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_TIME_STEP = 3'd1;
    localparam logic [2:0] CFG_COUPLING  = 3'd2;
    localparam logic [2:0] CFG_ASPECT_SQ = 3'd3;
    localparam logic [2:0] CFG_TILT_COS  = 3'd4;
    localparam logic [2:0] CFG_TILT_SIN  = 3'd5;

    // Operating modes
    localparam logic [1:0] MODE_IMAG        = 2'd0;
    localparam logic [1:0] MODE_REAL_BEFORE = 2'd1;
    localparam logic [1:0] MODE_REAL_TILT   = 2'd2;
    localparam logic [1:0] MODE_REAL_AFTER  = 2'd3;

    // Reset values
    localparam logic [30:0] ASPECT_SQ_RESET = 31'd65536;
    localparam logic [31:0] TILT_COS_RESET  = 32'h4000_0000;

    // Saturation limits
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] psi_re;
        logic signed [31:0] psi_im;
        logic signed [31:0] potential;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] out_re;
        logic signed [31:0] out_im;
        logic               saturated;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [30:0]        time_step;
        logic signed [31:0] coupling;
        logic [30:0]        aspect_squared;
        logic signed [31:0] tilt_cos;
        logic signed [31:0] tilt_sin;
    } cfg_t;

    // Clip a wide signed value to 32 bits; the top bit flags clipping.
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > SAT_MAX)
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < SAT_MIN)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Scale a Q32.32 square down to Q16.16 and clamp to 32 unsigned bits.
    function automatic logic [32:0] clamp_square(input logic [63:0] sq);
        logic [32:0] r;
        if (|sq[63:48])
        begin
            r = {1'b1, 32'hFFFF_FFFF};
        end
        else
        begin
            r = {1'b0, sq[47:16]};
        end
        return r;
    endfunction

    // Magnitude of a signed 32-bit value as 32 unsigned bits.
    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        logic [31:0] r;
        r = a[31] ? 32'(-a) : 32'(a);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/nonlinear_potential_operator.sv =====
// ----------------------------------------------------------------------------
// nonlinear_potential_operator
// Gross-Pitaevskii nonlinear and potential operator, one grid point a beat.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall | in_data  (in_beat_t)
//   out     | output    | out_valid/out_stall | out_data (out_beat_t)
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
// One beat enters per cycle while in_stall is low; each result passes through
// the eleven register stages of the multiply and saturate chain.
// Reset clears all stage valid bits and loads the register defaults.
// A stall on out holds the output register; stages behind it keep filling
// bubbles, and in_stall rises only once every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module nonlinear_potential_operator
    import npo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_beat_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_beat_t        out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t                  cfg_reg, cfg_next;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES:0]   ready;

    logic [30:0]           v_trap;
    logic                  trap_clip;
    logic signed [31:0]    nl, re_d, im_d, pot_d;
    logic                  nl_clip;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MODE:      cfg_next.mode           = cfg_data[1:0];
                CFG_TIME_STEP: cfg_next.time_step      = cfg_data[30:0];
                CFG_COUPLING:  cfg_next.coupling       = signed'(cfg_data);
                CFG_ASPECT_SQ: cfg_next.aspect_squared = cfg_data[30:0];
                CFG_TILT_COS:  cfg_next.tilt_cos       = signed'(cfg_data);
                CFG_TILT_SIN:  cfg_next.tilt_sin       = signed'(cfg_data);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode           <= MODE_IMAG;
            cfg_reg.time_step      <= '0;
            cfg_reg.coupling       <= '0;
            cfg_reg.aspect_squared <= ASPECT_SQ_RESET;
            cfg_reg.tilt_cos       <= signed'(TILT_COS_RESET);
            cfg_reg.tilt_sin       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Propagate ready back from the output; a stage loads when empty or moving
    assign ready[NUM_STAGES] = !out_stall;
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_ready
        assign ready[k] = !valid_reg[k] || ready[k+1];
    end

    // Move valid bits with the data
    assign valid_next[0] = ready[0] ? in_valid : valid_reg[0];
    for (genvar k = 1; k < NUM_STAGES; k++)
    begin : g_valid
        assign valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    npo_trap u_trap (
        .clk       (clk),
        .en        (ready[FRONT_STAGES-1:0]),
        .cfg       (cfg_reg),
        .x_coord   (in_data.x_coord),
        .y_coord   (in_data.y_coord),
        .z_coord   (in_data.z_coord),
        .v_trap    (v_trap),
        .trap_clip (trap_clip)
    );

    npo_nonlin u_nonlin (
        .clk       (clk),
        .en        (ready[FRONT_STAGES-1:0]),
        .cfg       (cfg_reg),
        .psi_re    (in_data.psi_re),
        .psi_im    (in_data.psi_im),
        .potential (in_data.potential),
        .nl        (nl),
        .nl_clip   (nl_clip),
        .re_d      (re_d),
        .im_d      (im_d),
        .pot_d     (pot_d)
    );

    npo_scale u_scale (
        .clk       (clk),
        .en        (ready[NUM_STAGES-1:FRONT_STAGES]),
        .cfg       (cfg_reg),
        .v_trap    (v_trap),
        .trap_clip (trap_clip),
        .nl        (nl),
        .nl_clip   (nl_clip),
        .re_d      (re_d),
        .im_d      (im_d),
        .pot_d     (pot_d),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== src/npo_trap.sv =====
// ----------------------------------------------------------------------------
// npo_trap
// Rotated harmonic trap potential 0.25*(x^2 + Yt^2 + L^2*Zt^2), six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module npo_trap
    import npo_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [FRONT_STAGES-1:0] en,
    input  wire cfg_t                    cfg,
    input  wire logic signed [31:0]      x_coord,
    input  wire logic signed [31:0]      y_coord,
    input  wire logic signed [31:0]      z_coord,
    output logic [30:0]                  v_trap,
    output logic                         trap_clip
);

    // Stage 0: rotation products and x square
    logic signed [63:0] p_yc_reg, p_zs_reg, p_zc_reg, p_ys_reg;
    logic signed [63:0] p_yc_next, p_zs_next, p_zc_next, p_ys_next;
    logic [63:0]        sq_x_reg, sq_x_next;
    // Stage 1: rotated coordinates, x square clamped
    logic signed [31:0] yt_reg, zt_reg, yt_next, zt_next;
    logic [31:0]        qx1_reg, qx1_next;
    logic               clip1_reg, clip1_next;
    // Stage 2: rotated squares
    logic [63:0]        sq_y_reg, sq_z_reg, sq_y_next, sq_z_next;
    logic [31:0]        qx2_reg;
    logic               clip2_reg;
    // Stage 3: rotated squares clamped
    logic [31:0]        qx3_reg, qy3_reg, qz3_reg, qy3_next, qz3_next;
    logic               clip3_reg, clip3_next;
    // Stage 4: aspect scaling of the z term
    logic [46:0]        lz_reg, lz_next;
    logic [31:0]        qx4_reg, qy4_reg;
    logic               clip4_reg;
    // Stage 5: quarter sum, saturated
    logic [30:0]        v_reg, v_next;
    logic               clip5_reg, clip5_next;

    logic signed [63:0] yt_sum, zt_sum;
    logic [32:0]        yt_sat, zt_sat, qx_sat, qy_sat, qz_sat;
    logic [62:0]        lz_full;
    logic [47:0]        quad_sum;
    logic [45:0]        quarter;

    // Form products and rotations
    always_comb
    begin
        p_yc_next = y_coord * cfg.tilt_cos;
        p_zs_next = z_coord * cfg.tilt_sin;
        p_zc_next = z_coord * cfg.tilt_cos;
        p_ys_next = y_coord * cfg.tilt_sin;
        sq_x_next = mag32(x_coord) * mag32(x_coord);

        yt_sum     = (p_yc_reg >>> 30) + (p_zs_reg >>> 30);
        zt_sum     = (p_zc_reg >>> 30) - (p_ys_reg >>> 30);
        yt_sat     = sat32(yt_sum);
        zt_sat     = sat32(zt_sum);
        qx_sat     = clamp_square(sq_x_reg);
        yt_next    = signed'(yt_sat[31:0]);
        zt_next    = signed'(zt_sat[31:0]);
        qx1_next   = qx_sat[31:0];
        clip1_next = yt_sat[32] | zt_sat[32] | qx_sat[32];

        sq_y_next = mag32(yt_reg) * mag32(yt_reg);
        sq_z_next = mag32(zt_reg) * mag32(zt_reg);

        qy_sat     = clamp_square(sq_y_reg);
        qz_sat     = clamp_square(sq_z_reg);
        qy3_next   = qy_sat[31:0];
        qz3_next   = qz_sat[31:0];
        clip3_next = clip2_reg | qy_sat[32] | qz_sat[32];

        lz_full = cfg.aspect_squared * qz3_reg;
        lz_next = lz_full[62:16];

        quad_sum = 48'(qx4_reg) + 48'(qy4_reg) + 48'(lz_reg);
        quarter  = quad_sum[47:2];
        if (|quarter[45:31])
        begin
            v_next     = 31'h7FFF_FFFF;
            clip5_next = 1'b1;
        end
        else
        begin
            v_next     = quarter[30:0];
            clip5_next = clip4_reg;
        end
    end

    // Advance each stage on its enable
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_yc_reg <= p_yc_next;
            p_zs_reg <= p_zs_next;
            p_zc_reg <= p_zc_next;
            p_ys_reg <= p_ys_next;
            sq_x_reg <= sq_x_next;
        end
        if (en[1])
        begin
            yt_reg    <= yt_next;
            zt_reg    <= zt_next;
            qx1_reg   <= qx1_next;
            clip1_reg <= clip1_next;
        end
        if (en[2])
        begin
            sq_y_reg  <= sq_y_next;
            sq_z_reg  <= sq_z_next;
            qx2_reg   <= qx1_reg;
            clip2_reg <= clip1_reg;
        end
        if (en[3])
        begin
            qx3_reg   <= qx2_reg;
            qy3_reg   <= qy3_next;
            qz3_reg   <= qz3_next;
            clip3_reg <= clip3_next;
        end
        if (en[4])
        begin
            lz_reg    <= lz_next;
            qx4_reg   <= qx3_reg;
            qy4_reg   <= qy3_reg;
            clip4_reg <= clip3_reg;
        end
        if (en[5])
        begin
            v_reg     <= v_next;
            clip5_reg <= clip5_next;
        end
    end

    assign v_trap    = v_reg;
    assign trap_clip = clip5_reg;

endmodule

`default_nettype wire

// ===== src/npo_nonlin.sv =====
// ----------------------------------------------------------------------------
// npo_nonlin
// Density |psi|^2 and nonlinear term C*|psi|^2, aligned to the trap path.
// ----------------------------------------------------------------------------
`default_nettype none

module npo_nonlin
    import npo_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [FRONT_STAGES-1:0] en,
    input  wire cfg_t                    cfg,
    input  wire logic signed [31:0]      psi_re,
    input  wire logic signed [31:0]      psi_im,
    input  wire logic signed [31:0]      potential,
    output logic signed [31:0]           nl,
    output logic                         nl_clip,
    output logic signed [31:0]           re_d,
    output logic signed [31:0]           im_d,
    output logic signed [31:0]           pot_d
);

    // Sample carried alongside the arithmetic, one copy per stage
    logic signed [31:0] re_reg  [FRONT_STAGES];
    logic signed [31:0] im_reg  [FRONT_STAGES];
    logic signed [31:0] pot_reg [FRONT_STAGES];

    logic [63:0]        sq_re_reg, sq_im_reg, sq_re_next, sq_im_next;
    logic [30:0]        mag2_reg, mag2_next;
    logic               clip1_reg, clip1_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               clip2_reg;
    logic signed [31:0] nl3_reg, nl4_reg, nl5_reg, nl3_next;
    logic               clip3_reg, clip4_reg, clip5_reg, clip3_next;

    logic [64:0]        dens_sum;
    logic [48:0]        dens;
    logic [32:0]        nl_sat;

    // Square, sum, scale and multiply by the coupling
    always_comb
    begin
        sq_re_next = mag32(psi_re) * mag32(psi_re);
        sq_im_next = mag32(psi_im) * mag32(psi_im);

        dens_sum = 65'(sq_re_reg) + 65'(sq_im_reg);
        dens     = dens_sum[64:16];
        if (|dens[48:31])
        begin
            mag2_next  = 31'h7FFF_FFFF;
            clip1_next = 1'b1;
        end
        else
        begin
            mag2_next  = dens[30:0];
            clip1_next = 1'b0;
        end

        prod_next = cfg.coupling * signed'({1'b0, mag2_reg});

        nl_sat     = sat32(prod_reg >>> 16);
        nl3_next   = signed'(nl_sat[31:0]);
        clip3_next = clip2_reg | nl_sat[32];
    end

    // Advance the sample copies
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            re_reg[0]  <= psi_re;
            im_reg[0]  <= psi_im;
            pot_reg[0] <= potential;
        end
    end

    for (genvar k = 1; k < FRONT_STAGES; k++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                re_reg[k]  <= re_reg[k-1];
                im_reg[k]  <= im_reg[k-1];
                pot_reg[k] <= pot_reg[k-1];
            end
        end
    end

    // Advance the arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
        end
        if (en[1])
        begin
            mag2_reg  <= mag2_next;
            clip1_reg <= clip1_next;
        end
        if (en[2])
        begin
            prod_reg  <= prod_next;
            clip2_reg <= clip1_reg;
        end
        if (en[3])
        begin
            nl3_reg   <= nl3_next;
            clip3_reg <= clip3_next;
        end
        if (en[4])
        begin
            nl4_reg   <= nl3_reg;
            clip4_reg <= clip3_reg;
        end
        if (en[5])
        begin
            nl5_reg   <= nl4_reg;
            clip5_reg <= clip4_reg;
        end
    end

    assign nl      = nl5_reg;
    assign nl_clip = clip5_reg;
    assign re_d    = re_reg[FRONT_STAGES-1];
    assign im_d    = im_reg[FRONT_STAGES-1];
    assign pot_d   = pot_reg[FRONT_STAGES-1];

endmodule

`default_nettype wire

// ===== src/npo_scale.sv =====
// ----------------------------------------------------------------------------
// npo_scale
// Sum V + nl, scale by dt, multiply into psi and rotate by mode; five stages,
// the last one is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npo_scale
    import npo_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [BACK_STAGES-1:0] en,
    input  wire cfg_t                   cfg,
    input  wire logic [30:0]            v_trap,
    input  wire logic                   trap_clip,
    input  wire logic signed [31:0]     nl,
    input  wire logic                   nl_clip,
    input  wire logic signed [31:0]     re_d,
    input  wire logic signed [31:0]     im_d,
    input  wire logic signed [31:0]     pot_d,
    output out_beat_t                   out_data
);

    logic signed [31:0] s_reg, s_next;
    logic signed [63:0] dts_reg, dts_next;
    logic signed [31:0] g_reg, g_next;
    logic signed [63:0] pr_reg, pi_reg, pr_next, pi_next;
    logic               clip0_reg, clip1_reg, clip2_reg, clip3_reg;
    logic               clip0_next, clip2_next;
    logic signed [31:0] re_reg [3];
    logic signed [31:0] im_reg [3];
    out_beat_t          out_reg, out_next;

    logic               tilt;
    logic signed [31:0] v_sel;
    logic [32:0]        s_sat, g_sat, re_sat, im_sat;
    logic signed [63:0] pr_s, pi_s;

    always_comb
    begin
        // Pick the potential and add the nonlinear term
        tilt       = (cfg.mode == MODE_REAL_TILT);
        v_sel      = tilt ? signed'({1'b0, v_trap}) : pot_d;
        s_sat      = sat32(64'(v_sel) + 64'(nl));
        s_next     = signed'(s_sat[31:0]);
        clip0_next = nl_clip | (tilt & trap_clip) | s_sat[32];

        // Scale by the time step
        dts_next = signed'({1'b0, cfg.time_step}) * s_reg;

        g_sat      = sat32(dts_reg >>> 16);
        g_next     = signed'(g_sat[31:0]);
        clip2_next = clip1_reg | g_sat[32];

        // Multiply into the wavefunction
        pr_next = g_reg * re_reg[2];
        pi_next = g_reg * im_reg[2];

        // Negate or rotate by -i, then saturate
        pr_s = pr_reg >>> 16;
        pi_s = pi_reg >>> 16;
        if (cfg.mode == MODE_IMAG)
        begin
            re_sat = sat32(-pr_s);
            im_sat = sat32(-pi_s);
        end
        else
        begin
            re_sat = sat32(pi_s);
            im_sat = sat32(-pr_s);
        end
        out_next.out_re    = signed'(re_sat[31:0]);
        out_next.out_im    = signed'(im_sat[31:0]);
        out_next.saturated = clip3_reg | re_sat[32] | im_sat[32];
    end

    // Advance each stage on its enable
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg     <= s_next;
            clip0_reg <= clip0_next;
            re_reg[0] <= re_d;
            im_reg[0] <= im_d;
        end
        if (en[1])
        begin
            dts_reg   <= dts_next;
            clip1_reg <= clip0_reg;
            re_reg[1] <= re_reg[0];
            im_reg[1] <= im_reg[0];
        end
        if (en[2])
        begin
            g_reg     <= g_next;
            clip2_reg <= clip2_next;
            re_reg[2] <= re_reg[1];
            im_reg[2] <= im_reg[1];
        end
        if (en[3])
        begin
            pr_reg    <= pr_next;
            pi_reg    <= pi_next;
            clip3_reg <= clip2_reg;
        end
        if (en[4])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== tb/npo_operator_check.sv =====
// ----------------------------------------------------------------------------
// npo_operator_check
// Watches the in, out and cfg ports of the nonlinear potential operator.
// Keeps its own copy of the registers, predicts each result beat from the
// accepted input beat and compares the results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npo_operator_check
    import npo_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire in_beat_t    in_data,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire out_beat_t   out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               awaiting
);

    typedef longint unsigned u64_t;

    cfg_t      regs;
    out_beat_t predicted_points[$];
    int        errs = 0;

    // Clip to the signed 32-bit range and flag the clip.
    function automatic longint clip32(input longint v, inout bit hit);
        longint r;
        r = v;
        if (v > SAT_MAX)
        begin
            hit = 1'b1;
            r   = SAT_MAX;
        end
        else if (v < SAT_MIN)
        begin
            hit = 1'b1;
            r   = SAT_MIN;
        end
        return r;
    endfunction

    // Q16.16 square of a coordinate, clamped to 32 unsigned bits.
    function automatic u64_t square_q16(input longint a, inout bit hit);
        u64_t m;
        u64_t q;
        m = (a < 0) ? u64_t'(-a) : u64_t'(a);
        q = (m * m) >> 16;
        if (q > 64'hFFFF_FFFF)
        begin
            hit = 1'b1;
            q   = 64'hFFFF_FFFF;
        end
        return q;
    endfunction

    // Compute -g*psi or -i*g*psi for one grid point under the current registers.
    function automatic out_beat_t apply_operator(input in_beat_t b);
        longint    re, im, x, y, z, tc, ts;
        longint    nl, v, s, g, prod_re, prod_im, yt, zt, o_re, o_im;
        u64_t      mre, mim, m2, qx, qy, qz, lz, trap;
        bit        hit;
        out_beat_t r;
        hit = 1'b0;
        re  = longint'($signed(b.psi_re));
        im  = longint'($signed(b.psi_im));
        x   = longint'($signed(b.x_coord));
        y   = longint'($signed(b.y_coord));
        z   = longint'($signed(b.z_coord));
        tc  = longint'($signed(regs.tilt_cos));
        ts  = longint'($signed(regs.tilt_sin));

        // density |psi|^2, held to the positive range
        mre = (re < 0) ? u64_t'(-re) : u64_t'(re);
        mim = (im < 0) ? u64_t'(-im) : u64_t'(im);
        m2  = (mre * mre + mim * mim) >> 16;
        if (m2 > 64'h7FFF_FFFF)
        begin
            hit = 1'b1;
            m2  = 64'h7FFF_FFFF;
        end
        nl = clip32((longint'($signed(regs.coupling)) * longint'(m2)) >>> 16, hit);

        // rotated trap in the tilt mode, sampled potential otherwise
        if (regs.mode == MODE_REAL_TILT)
        begin
            yt   = clip32(((y * tc) >>> 30) + ((z * ts) >>> 30), hit);
            zt   = clip32(((z * tc) >>> 30) - ((y * ts) >>> 30), hit);
            qx   = square_q16(x, hit);
            qy   = square_q16(yt, hit);
            qz   = square_q16(zt, hit);
            lz   = (u64_t'(regs.aspect_squared) * qz) >> 16;
            trap = (qx + qy + lz) >> 2;
            if (trap > 64'h7FFF_FFFF)
            begin
                hit  = 1'b1;
                trap = 64'h7FFF_FFFF;
            end
            v = longint'(trap);
        end
        else
        begin
            v = longint'($signed(b.potential));
        end

        s       = clip32(v + nl, hit);
        g       = clip32((longint'(regs.time_step) * s) >>> 16, hit);
        prod_re = (g * re) >>> 16;
        prod_im = (g * im) >>> 16;

        if (regs.mode == MODE_IMAG)
        begin
            o_re = clip32(-prod_re, hit);
            o_im = clip32(-prod_im, hit);
        end
        else
        begin
            o_re = clip32(prod_im, hit);
            o_im = clip32(-prod_re, hit);
        end

        r.out_re    = o_re[31:0];
        r.out_im    = o_im[31:0];
        r.saturated = hit;
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            regs.mode           = MODE_IMAG;
            regs.time_step      = '0;
            regs.coupling       = '0;
            regs.aspect_squared = ASPECT_SQ_RESET;
            regs.tilt_cos       = TILT_COS_RESET;
            regs.tilt_sin       = '0;
            predicted_points.delete();
        end
        else
        begin
            // track register writes; unknown indexes drop
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE:      regs.mode           = cfg_data[1:0];
                    CFG_TIME_STEP: regs.time_step      = cfg_data[30:0];
                    CFG_COUPLING:  regs.coupling       = cfg_data;
                    CFG_ASPECT_SQ: regs.aspect_squared = cfg_data[30:0];
                    CFG_TILT_COS:  regs.tilt_cos       = cfg_data;
                    CFG_TILT_SIN:  regs.tilt_sin       = cfg_data;
                    default:       ;
                endcase
            end

            // compare a result beat with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (predicted_points.size() == 0)
                begin
                    $error("result beat arrived with no prediction pending");
                    errs++;
                end
                else
                begin
                    want = predicted_points.pop_front();
                    if (out_data.out_re !== want.out_re)
                    begin
                        $error("out_re: expected %0d, got %0d",
                               $signed(want.out_re), $signed(out_data.out_re));
                        errs++;
                    end
                    if (out_data.out_im !== want.out_im)
                    begin
                        $error("out_im: expected %0d, got %0d",
                               $signed(want.out_im), $signed(out_data.out_im));
                        errs++;
                    end
                    if (out_data.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               want.saturated, out_data.saturated);
                        errs++;
                    end
                end
            end

            // predict every accepted input beat
            if (in_valid && !in_stall)
            begin
                predicted_points.push_back(apply_operator(in_data));
            end
        end
        fail_count <= errs;
        awaiting   <= predicted_points.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the nonlinear potential operator. Runs a directed
// pass over all modes, register extremes and clipping cases, then random
// register settings with random grid points under three idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import npo_pkg::*;
();

    localparam int          RANDOM_POINTS  = 1900;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [2:0]  CFG_UNUSED_LO  = 3'd6;
    localparam logic [2:0]  CFG_UNUSED_HI  = 3'd7;
    localparam logic [31:0] Q_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN          = 32'h8000_0000;
    localparam logic [31:0] Q_ONE          = 32'h0001_0000;
    localparam logic [31:0] Q_ZERO         = 32'h0000_0000;
    localparam logic [31:0] COS_45         = 32'h2D41_3CCD;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_beat_t   out_data;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          awaiting;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned quiet_cycles  = 0;

    nonlinear_potential_operator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    npo_operator_check operator_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // End the run when no beat moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_beat_t make_point(input logic [31:0] re, input logic [31:0] im,
                                            input logic [31:0] pot, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
        in_beat_t b;
        b.psi_re    = re;
        b.psi_im    = im;
        b.potential = pot;
        b.x_coord   = x;
        b.y_coord   = y;
        b.z_coord   = z;
        return b;
    endfunction

    // Signed value: mostly near zero, some full range, some range limits.
    function automatic logic [31:0] pick_value(input int unsigned span);
        int unsigned sel;
        int          v;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            v = int'($urandom_range(2 * span)) - int'(span);
            return v;
        end
        else if (sel < 80)
        begin
            return $urandom;
        end
        case ($urandom_range(4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return Q_ZERO;
            3:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Unsigned register value: mostly small, some full range, some limits.
    function automatic logic [31:0] pick_scale(input int unsigned span);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            return $urandom_range(span);
        end
        else if (sel < 85)
        begin
            return $urandom;
        end
        return ($urandom_range(1) == 0) ? Q_ZERO : 32'hFFFF_FFFF;
    endfunction

    function automatic in_beat_t random_point();
        return make_point(pick_value(1 << 18), pick_value(1 << 18), pick_value(1 << 20),
                          pick_value(1 << 19), pick_value(1 << 19), pick_value(1 << 19));
    endfunction

    // Hand one beat over; leave valid up so back-to-back beats need no gap.
    task automatic send_beat(input in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Hold the input side until every predicted result has come out.
    task automatic drain_points();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_random_setting();
        real ang;
        write_reg(CFG_MODE, $urandom);
        write_reg(CFG_TIME_STEP, pick_scale(8192));
        write_reg(CFG_COUPLING, pick_value(1 << 20));
        write_reg(CFG_ASPECT_SQ, pick_scale(1 << 19));
        // mostly a real rotation, sometimes arbitrary values
        if ($urandom_range(99) < 60)
        begin
            ang = $urandom_range(6283) / 1000.0;
            write_reg(CFG_TILT_COS, $rtoi($cos(ang) * 1073741824.0));
            write_reg(CFG_TILT_SIN, $rtoi($sin(ang) * 1073741824.0));
        end
        else
        begin
            write_reg(CFG_TILT_COS, pick_value(1 << 30));
            write_reg(CFG_TILT_SIN, pick_value(1 << 30));
        end
    endtask

    initial
    begin
        int sent;
        int seg;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // register defaults: zero time step gives zero output
        send_beat(make_point(Q_ONE, -Q_ONE, 32'h0002_0000, Q_ONE, Q_ONE, Q_ONE));
        drain_points();

        // imaginary time, unit step and coupling
        write_reg(CFG_MODE, MODE_IMAG);
        write_reg(CFG_TIME_STEP, Q_ONE);
        write_reg(CFG_COUPLING, Q_ONE);
        send_beat(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(Q_ONE, 32'h0000_8000, 32'h0002_0000, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(Q_MAX, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(Q_MIN, Q_MIN, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(Q_ONE, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(32'hFFFF_FFFF, 32'h0000_0001, -Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
        drain_points();

        // real time before tilt, largest step and most negative coupling
        write_reg(CFG_MODE, MODE_REAL_BEFORE);
        write_reg(CFG_TIME_STEP, Q_MAX);
        write_reg(CFG_COUPLING, Q_MIN);
        send_beat(make_point(Q_ONE, -Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(Q_MIN, Q_ZERO, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO));
        send_beat(make_point(32'd100000, 32'd200000, -32'sd300000, Q_ZERO, Q_ZERO, Q_ZERO));
        drain_points();

        // real time after tilt; coordinates must not matter here
        write_reg(CFG_MODE, MODE_REAL_AFTER);
        write_reg(CFG_TIME_STEP, 32'h0000_1000);
        write_reg(CFG_COUPLING, Q_MAX);
        send_beat(make_point(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_beat(make_point(-Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_ONE, Q_MAX));
        drain_points();

        // tilt mode through masked writes, plus writes to unused indexes
        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        write_reg(CFG_TIME_STEP, 32'h8001_0000);
        write_reg(CFG_COUPLING, 32'h0000_4000);
        write_reg(CFG_ASPECT_SQ, 32'h0004_0000);
        write_reg(CFG_TILT_COS, COS_45);
        write_reg(CFG_TILT_SIN, COS_45);
        write_reg(CFG_UNUSED_LO, 32'hDEAD_BEEF);
        write_reg(CFG_UNUSED_HI, Q_MIN);
        send_beat(make_point(Q_ONE, Q_ZERO, Q_MAX, Q_ONE, 32'h0002_0000, -Q_ONE));
        send_beat(make_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX, Q_MIN, Q_MAX));
        send_beat(make_point(Q_ONE, Q_ONE, Q_ZERO, Q_MIN, Q_MIN, Q_MIN));
        drain_points();

        // tilt at the register limits
        write_reg(CFG_TILT_COS, Q_MIN);
        write_reg(CFG_TILT_SIN, Q_MAX);
        write_reg(CFG_ASPECT_SQ, Q_MAX);
        send_beat(make_point(Q_ONE, Q_ZERO, Q_ZERO, Q_MIN, Q_MAX, Q_MIN));
        send_beat(make_point(32'h0000_8000, 32'hFFFF_8000, Q_ZERO,
                             32'h0003_0000, 32'hFFFE_0000, 32'h0005_0000));
        drain_points();

        // random settings and points under each idle pattern
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 77;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_POINTS / 3)
            begin
                drain_points();
                load_random_setting();
                seg = $urandom_range(40, 120);
                // trim the last segment to the phase's share
                if (seg > RANDOM_POINTS / 3 - sent)
                begin
                    seg = RANDOM_POINTS / 3 - sent;
                end
                repeat (seg)
                begin
                    send_beat(random_point());
                end
                sent += seg;
            end
        end

        // wait out the pipeline, then give the verdict
        drain_points();
        repeat (NUM_STAGES + 4) @(posedge clk);
        if (fail_count == 0 && awaiting == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
